### hdl/core_pool_allocator_defines.svh
// assertion macros shared by the core pool allocator
`ifndef CORE_POOL_ALLOCATOR_DEFINES_SVH
`define CORE_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cpa_pkg.sv
// shared types and constants of the core pool allocator
package cpa_pkg;

    localparam int CORE_W = 4;
    localparam int MASK_W = 16;
    localparam int PID_W  = 23;
    localparam int WANT_W = 5;

    localparam logic FUNC_SET = 1'b0;
    localparam logic FUNC_REL = 1'b1;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    // control of the free core queue
    typedef struct packed {
        logic              push;
        logic [CORE_W-1:0] push_core;
        logic              pop;
    } t_fifo_ctl;

endpackage

### hdl/cpa_free_fifo.sv
// free core queue: ring buffer in a synchronous memory with an init sweep
module cpa_free_fifo #(
    parameter int DEPTH  = 16,
    parameter int INIT_N = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cpa_pkg::t_fifo_ctl        i_ctl,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic [cpa_pkg::CORE_W-1:0] o_head_core,
    output logic                      o_ready
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] INIT_C   = CNT_W'(INIT_N);
    localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);

    logic [cpa_pkg::CORE_W-1:0] mem [DEPTH];

    logic                       r_init;
    logic [CNT_W-1:0]           r_init_idx;
    logic [AW-1:0]              r_head;
    logic [CNT_W-1:0]           r_count;
    logic [cpa_pkg::CORE_W-1:0] r_q;

    logic [CNT_W:0]             tail_sum;
    logic [AW-1:0]              tail;

    // tail position, head plus count modulo depth
    always_comb begin
        tail_sum = {1'b0, CNT_W'(r_head)} + {1'b0, r_count};
        if (tail_sum >= {1'b0, DEPTH_C}) begin
            tail_sum = tail_sum - {1'b0, DEPTH_C};
        end
        tail = tail_sum[AW-1:0];
    end

    // storage: init sweep, push at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (r_init) begin
            mem[r_init_idx[AW-1:0]] <= cpa_pkg::CORE_W'(r_init_idx);
        end else if (i_ctl.push && (r_count < DEPTH_C)) begin
            mem[tail] <= i_ctl.push_core;
        end
        if (i_ctl.pop) begin
            r_q <= mem[r_head];
        end
    end

    // pointers and sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b1;
            r_init_idx <= '0;
            r_head     <= '0;
            r_count    <= INIT_C;
        end else begin
            if (r_init) begin
                r_init_idx <= r_init_idx + 1'b1;
                if (r_init_idx == INIT_C - 1'b1) begin
                    r_init <= 1'b0;
                end
            end else if (i_ctl.pop) begin
                r_head  <= (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end else if (i_ctl.push && (r_count < DEPTH_C)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_count     = r_count;
    assign o_head_core = r_q;
    assign o_ready     = !r_init;

endmodule

### hdl/core_pool_allocator.sv
// core pool allocator: free core queue plus per-application core stacks
//
// A request beat is taken when start is high and busy is low: func 0 sets the
// app's held core count to want_count (0 counts as 1) as far as free managed
// cores allow, func 1 releases all of the app's cores. mask_we writes
// managed_mask; the user must write it only while the block is idle, as the
// block itself does not enforce this. Results come back as beats marked by
// o_strobe, one cycle each; the receiver cannot stall them. A set lists the
// held cores bottom of stack first, with o_last on the final beat; every other
// outcome is a single beat with o_last. The pid table is scanned one slot a
// cycle from its memory; a release then pushes each held core back to the
// free queue, while a set compares counts, then shrinks by pushing surplus
// cores back or grows by examining free queue entries (one memory read then
// one write each), and lists the held cores, or gives one empty beat when
// none is held. Busy falls with the last beat; one request at a time.
// After reset the free queue memory is filled with cores 0 to
// min(NUM_CORES, 16) - 1 in ascending order while busy is high; mask writes
// are taken during that time.
`include "core_pool_allocator_defines.svh"

module core_pool_allocator #(
    parameter int NUM_CORES = 16,
    parameter int APP_SLOTS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [cpa_pkg::PID_W-1:0]   i_app_id,
    input  logic [cpa_pkg::WANT_W-1:0]  i_want_count,
    input  logic                        i_mask_we,
    input  logic [cpa_pkg::MASK_W-1:0]  i_mask_wdata,
    output logic                        o_strobe,
    output logic [cpa_pkg::CORE_W-1:0]  o_core_id,
    output logic                        o_core_valid,
    output logic                        o_status,
    output logic                        o_last
);

    localparam int CW     = $clog2(NUM_CORES);
    localparam int HW     = $clog2(NUM_CORES + 1);
    localparam int SW     = (APP_SLOTS > 1) ? $clog2(APP_SLOTS) : 1;
    localparam int INIT_N = (NUM_CORES < 16) ? NUM_CORES : 16;
    localparam int CMPW   = (HW > cpa_pkg::WANT_W) ? HW : cpa_pkg::WANT_W;
    localparam logic [HW-1:0] NC_C      = HW'(NUM_CORES);
    localparam logic [SW-1:0] LAST_SLOT = SW'(APP_SLOTS - 1);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_CMP    = 4'd3;
    localparam logic [3:0] ST_DEC    = 4'd4;
    localparam logic [3:0] ST_REL    = 4'd5;
    localparam logic [3:0] ST_ADJ    = 4'd6;
    localparam logic [3:0] ST_SHRINK = 4'd7;
    localparam logic [3:0] ST_GRD    = 4'd8;
    localparam logic [3:0] ST_GWR    = 4'd9;
    localparam logic [3:0] ST_LIST   = 4'd10;

    // memories
    logic [cpa_pkg::PID_W-1:0]  pid_mem   [APP_SLOTS];
    logic [HW-1:0]              hcnt_mem  [APP_SLOTS];
    logic [cpa_pkg::CORE_W-1:0] stack_mem [2**(SW+CW)];

    logic [3:0]                 r_state, n_state;
    logic [cpa_pkg::MASK_W-1:0] r_mask;
    logic [APP_SLOTS-1:0]       r_used, n_used;
    logic                       r_func, n_func;
    logic [cpa_pkg::PID_W-1:0]  r_pid, n_pid;
    logic [cpa_pkg::WANT_W-1:0] r_want, n_want;
    logic [SW-1:0]              r_idx, n_idx;
    logic [SW-1:0]              r_cidx;
    logic                       r_cv, n_cv;
    logic [cpa_pkg::PID_W-1:0]  r_pid_q;
    logic [HW-1:0]              r_hcq;
    logic                       r_found, n_found;
    logic                       r_free_v, n_free_v;
    logic [SW-1:0]              r_slot, n_slot;
    logic [SW-1:0]              r_fslot, n_fslot;
    logic [HW-1:0]              r_hcnt, n_hcnt;
    logic [HW-1:0]              r_k, n_k;
    logic [cpa_pkg::WANT_W-1:0] r_need, n_need;
    logic [HW-1:0]              r_tries, n_tries;
    logic                       r_sv, n_sv;
    logic                       r_slist, n_slist;
    logic                       r_slast, n_slast;
    logic [cpa_pkg::CORE_W-1:0] r_sq;
    logic                       r_res_v, n_res_v;
    logic                       r_res_stat, n_res_stat;

    logic [SW+CW-1:0]           s_rd_addr;
    logic                       s_wr_en;
    logic [SW+CW-1:0]           s_wr_addr;
    logic                       pid_we;
    logic                       hcnt_we;
    logic [CMPW-1:0]            hcnt_x, want_x;
    logic                       hit, unused;
    logic                       head_managed;
    logic                       fifo_pop;

    cpa_pkg::t_fifo_ctl         fifo_ctl;
    logic [HW-1:0]              fifo_count;
    logic [cpa_pkg::CORE_W-1:0] fifo_core;
    logic                       fifo_ready;

    cpa_free_fifo #(
        .DEPTH  (NUM_CORES),
        .INIT_N (INIT_N)
    ) u_free (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fifo_ctl),
        .o_count     (fifo_count),
        .o_head_core (fifo_core),
        .o_ready     (fifo_ready)
    );

    assign hcnt_x       = CMPW'(r_hcnt);
    assign want_x       = CMPW'(r_want);
    assign hit          = r_used[r_cidx] && (r_pid_q == r_pid);
    assign unused       = !r_used[r_cidx];
    assign head_managed = r_mask[fifo_core];

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_func     = r_func;
        n_pid      = r_pid;
        n_want     = r_want;
        n_idx      = r_idx;
        n_cv       = 1'b0;
        n_found    = r_found;
        n_free_v   = r_free_v;
        n_slot     = r_slot;
        n_fslot    = r_fslot;
        n_hcnt     = r_hcnt;
        n_k        = r_k;
        n_need     = r_need;
        n_tries    = r_tries;
        n_sv       = 1'b0;
        n_slist    = r_slist;
        n_slast    = 1'b0;
        n_res_v    = 1'b0;
        n_res_stat = cpa_pkg::STAT_OK;
        s_rd_addr  = {r_slot, r_k[CW-1:0]};
        s_wr_en    = 1'b0;
        s_wr_addr  = {r_slot, r_hcnt[CW-1:0]};
        pid_we     = 1'b0;
        hcnt_we    = 1'b0;
        fifo_pop   = 1'b0;

        // compare stage of the pid scan
        if (r_cv) begin
            if (hit && !r_found) begin
                n_found = 1'b1;
                n_slot  = r_cidx;
                n_hcnt  = r_hcq;
            end
            if (unused && !r_free_v) begin
                n_free_v = 1'b1;
                n_fslot  = r_cidx;
            end
        end

        unique case (r_state)
            ST_INIT: begin
                if (fifo_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_func   = i_func;
                    n_pid    = i_app_id;
                    n_want   = (i_want_count == '0) ? cpa_pkg::WANT_W'(1) : i_want_count;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_free_v = 1'b0;
                    n_hcnt   = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_cv = 1'b1;
                if (r_idx == LAST_SLOT) begin
                    n_state = ST_CMP;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_CMP: begin
                n_state = ST_DEC;
            end
            ST_DEC: begin
                if (r_func == cpa_pkg::FUNC_REL) begin
                    n_k = '0;
                    if (r_found) begin
                        n_state = ST_REL;
                    end else begin
                        n_res_v = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (!r_found && !r_free_v) begin
                    n_res_v    = 1'b1;
                    n_res_stat = cpa_pkg::STAT_FULL;
                    n_state    = ST_IDLE;
                end else begin
                    if (!r_found) begin
                        n_slot                = r_fslot;
                        n_hcnt                = '0;
                        n_used[r_fslot]       = 1'b1;
                        pid_we                = 1'b1;
                    end
                    n_state = ST_ADJ;
                end
            end
            ST_REL: begin
                if (r_k < r_hcnt) begin
                    n_sv    = 1'b1;
                    n_slist = 1'b0;
                    n_k     = r_k + 1'b1;
                end else begin
                    n_used[r_slot] = 1'b0;
                    n_res_v        = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_ADJ: begin
                n_k = '0;
                if (hcnt_x > want_x) begin
                    n_state = ST_SHRINK;
                end else if (hcnt_x < want_x) begin
                    n_need  = cpa_pkg::WANT_W'(want_x - hcnt_x);
                    n_tries = fifo_count;
                    n_state = ST_GRD;
                end else begin
                    n_state = ST_LIST;
                end
            end
            ST_SHRINK: begin
                if (hcnt_x > want_x) begin
                    s_rd_addr = {r_slot, CW'(r_hcnt - 1'b1)};
                    n_hcnt    = r_hcnt - 1'b1;
                    n_sv      = 1'b1;
                    n_slist   = 1'b0;
                end else begin
                    n_state = ST_LIST;
                end
            end
            ST_GRD: begin
                if ((r_tries != '0) && (r_need != '0) && (r_hcnt < NC_C)) begin
                    fifo_pop = 1'b1;
                    n_tries  = r_tries - 1'b1;
                    n_state  = ST_GWR;
                end else begin
                    n_state = ST_LIST;
                end
            end
            ST_GWR: begin
                if (head_managed) begin
                    s_wr_en = 1'b1;
                    n_hcnt  = r_hcnt + 1'b1;
                    n_need  = r_need - 1'b1;
                end
                n_state = ST_GRD;
            end
            ST_LIST: begin
                hcnt_we = 1'b1;
                if (r_hcnt == '0) begin
                    n_res_v = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_sv    = 1'b1;
                    n_slist = 1'b1;
                    n_k     = r_k + 1'b1;
                    if (r_k == r_hcnt - 1'b1) begin
                        n_slast = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // free queue control: pops from the sequencer, pushes of popped stack
    // entries or of an unmanaged head going round
    always_comb begin
        fifo_ctl.pop       = fifo_pop;
        fifo_ctl.push      = 1'b0;
        fifo_ctl.push_core = r_sq;
        if (r_sv && !r_slist) begin
            fifo_ctl.push = 1'b1;
        end else if ((r_state == ST_GWR) && !head_managed) begin
            fifo_ctl.push      = 1'b1;
            fifo_ctl.push_core = fifo_core;
        end
    end

    // slot table memories, read during the scan
    always_ff @(posedge i_clk) begin
        if (pid_we) begin
            pid_mem[r_fslot] <= r_pid;
        end
        if (hcnt_we) begin
            hcnt_mem[r_slot] <= r_hcnt;
        end
        r_pid_q <= pid_mem[r_idx];
        r_hcq   <= hcnt_mem[r_idx];
        r_cidx  <= r_idx;
    end

    // held core stacks
    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            stack_mem[s_wr_addr] <= fifo_core;
        end
        r_sq <= stack_mem[s_rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_mask     <= '1;
            r_used     <= '0;
            r_cv       <= 1'b0;
            r_sv       <= 1'b0;
            r_slist    <= 1'b0;
            r_slast    <= 1'b0;
            r_res_v    <= 1'b0;
            r_res_stat <= cpa_pkg::STAT_OK;
            r_found    <= 1'b0;
            r_free_v   <= 1'b0;
            r_hcnt     <= '0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_cv       <= n_cv;
            r_sv       <= n_sv;
            r_slist    <= n_slist;
            r_slast    <= n_slast;
            r_res_v    <= n_res_v;
            r_res_stat <= n_res_stat;
            r_found    <= n_found;
            r_free_v   <= n_free_v;
            r_hcnt     <= n_hcnt;
            if (i_mask_we) begin
                r_mask <= i_mask_wdata;
            end
        end
    end

    // request payload and counters
    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_pid   <= n_pid;
        r_want  <= n_want;
        r_idx   <= n_idx;
        r_slot  <= n_slot;
        r_fslot <= n_fslot;
        r_k     <= n_k;
        r_need  <= n_need;
        r_tries <= n_tries;
    end

    // result beat
    assign busy         = (r_state != ST_IDLE);
    assign o_strobe     = r_res_v || (r_sv && r_slist);
    assign o_core_id    = r_res_v ? '0 : r_sq;
    assign o_core_valid = !r_res_v && r_sv && r_slist;
    assign o_status     = r_res_v && r_res_stat;
    assign o_last       = r_res_v || r_slast;

    `CPA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `CPA_ASSERT_IMP(a_full_beat, o_strobe && o_status, o_last && !o_core_valid, "bad full beat")
    `CPA_ASSERT_IMP(a_hcnt_range, 1'b1, r_hcnt <= NC_C, "held count beyond core count")
    `CPA_ASSERT_IMP(a_init_quiet, r_state == ST_INIT, !o_strobe, "result beat during init")

endmodule

### tb/core_pool_allocator_test.sv
// testbench of the core pool allocator: scoreboard class, request driver and result checker
module core_pool_allocator_test;

    localparam int NCORE  = 16;
    localparam int NSLOT  = 8;
    localparam int LIMIT  = 600000;

    typedef struct {
        logic [cpa_pkg::CORE_W-1:0] core_id;
        logic                       core_valid;
        logic                       status;
        logic                       last;
    } t_grant_beat;

    // pool state mirror and expected grant beats
    class pool_scoreboard;
        logic [cpa_pkg::MASK_W-1:0] mask;
        logic [cpa_pkg::CORE_W-1:0] free_q[NCORE];
        int                         free_head;
        int                         free_cnt;
        logic [cpa_pkg::PID_W-1:0]  owner_pid[NSLOT];
        bit                         owner_used[NSLOT];
        logic [cpa_pkg::CORE_W-1:0] held[NSLOT][NCORE];
        int                         held_cnt[NSLOT];
        t_grant_beat                grants[$];
        int                         errors;

        function new();
            mask = '1;
            free_head = 0;
            free_cnt = NCORE;
            errors = 0;
            for (int c = 0; c < NCORE; c++) free_q[c] = cpa_pkg::CORE_W'(c);
            for (int s = 0; s < NSLOT; s++) begin
                owner_used[s] = 0;
                held_cnt[s] = 0;
                owner_pid[s] = '0;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void free_push(logic [cpa_pkg::CORE_W-1:0] c);
            if (free_cnt < NCORE) begin
                free_q[(free_head + free_cnt) % NCORE] = c;
                free_cnt++;
            end
        endfunction

        function logic [cpa_pkg::CORE_W-1:0] free_pop();
            logic [cpa_pkg::CORE_W-1:0] c;
            c = free_q[free_head];
            free_head = (free_head + 1) % NCORE;
            free_cnt--;
            return c;
        endfunction

        function void add_beat(logic [cpa_pkg::CORE_W-1:0] c, logic v, logic st, logic l);
            t_grant_beat b;
            b.core_id = c; b.core_valid = v; b.status = st; b.last = l;
            grants.insert(grants.size(), b);
        endfunction

        // work out the beats of one accepted request
        function void note_request(logic fn, logic [cpa_pkg::PID_W-1:0] pid,
                                   logic [cpa_pkg::WANT_W-1:0] want);
            int s, w, need, tries;
            logic [cpa_pkg::CORE_W-1:0] c;
            s = -1;
            for (int i = 0; i < NSLOT; i++)
                if (s < 0 && owner_used[i] && owner_pid[i] == pid) s = i;
            if (fn == cpa_pkg::FUNC_REL) begin
                if (s >= 0) begin
                    for (int k = 0; k < held_cnt[s]; k++) free_push(held[s][k]);
                    held_cnt[s] = 0;
                    owner_used[s] = 0;
                end
                add_beat('0, 1'b0, cpa_pkg::STAT_OK, 1'b1);
                return;
            end
            w = (want == 0) ? 1 : int'(want);
            if (s < 0) begin
                for (int i = 0; i < NSLOT; i++)
                    if (s < 0 && !owner_used[i]) s = i;
                if (s < 0) begin
                    add_beat('0, 1'b0, cpa_pkg::STAT_FULL, 1'b1);
                    return;
                end
                owner_used[s] = 1;
                owner_pid[s] = pid;
                held_cnt[s] = 0;
            end
            if (held_cnt[s] > w) begin
                while (held_cnt[s] > w) begin
                    held_cnt[s]--;
                    free_push(held[s][held_cnt[s]]);
                end
            end else if (held_cnt[s] < w) begin
                need = w - held_cnt[s];
                tries = free_cnt;
                while (tries > 0 && need > 0 && held_cnt[s] < NCORE) begin
                    c = free_pop();
                    if (mask[c]) begin
                        held[s][held_cnt[s]] = c;
                        held_cnt[s]++;
                        need--;
                    end else begin
                        // unmanaged core goes round to the tail
                        free_push(c);
                    end
                    tries--;
                end
            end
            if (held_cnt[s] == 0) begin
                add_beat('0, 1'b0, cpa_pkg::STAT_OK, 1'b1);
                return;
            end
            for (int k = 0; k < held_cnt[s]; k++)
                add_beat(held[s][k], 1'b1, cpa_pkg::STAT_OK, k + 1 == held_cnt[s]);
        endfunction

        // compare one result beat with the oldest expectation
        task check_beat(logic [cpa_pkg::CORE_W-1:0] c, logic v, logic st, logic l);
            t_grant_beat b;
            if (grants.size() == 0) begin
                report($sformatf("unexpected beat core %0d valid %0d status %0d last %0d",
                                 c, v, st, l));
                return;
            end
            b = grants.pop_front();
            if (c !== b.core_id || v !== b.core_valid || st !== b.status || l !== b.last)
                report($sformatf("got core %0d valid %0d status %0d last %0d, exp %0d %0d %0d %0d",
                                 c, v, st, l, b.core_id, b.core_valid, b.status, b.last));
        endtask
    endclass

    logic                        i_clk = 0;
    logic                        i_rst_n = 0;
    logic                        start = 0;
    logic                        busy;
    logic                        i_func = 0;
    logic [cpa_pkg::PID_W-1:0]   i_app_id = '0;
    logic [cpa_pkg::WANT_W-1:0]  i_want_count = '0;
    logic                        i_mask_we = 0;
    logic [cpa_pkg::MASK_W-1:0]  i_mask_wdata = '0;
    logic                        o_strobe;
    logic [cpa_pkg::CORE_W-1:0]  o_core_id;
    logic                        o_core_valid;
    logic                        o_status;
    logic                        o_last;

    pool_scoreboard              sb = new();
    int                          cycles = 0;
    bit                          calm = 0;
    logic [cpa_pkg::PID_W-1:0]   pid_pool[10];

    core_pool_allocator #(.NUM_CORES(NCORE), .APP_SLOTS(NSLOT)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_app_id(i_app_id), .i_want_count(i_want_count),
        .i_mask_we(i_mask_we), .i_mask_wdata(i_mask_wdata),
        .o_strobe(o_strobe), .o_core_id(o_core_id), .o_core_valid(o_core_valid),
        .o_status(o_status), .o_last(o_last)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // result beats and run limit
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_strobe)
            sb.check_beat(o_core_id, o_core_valid, o_status, o_last);
        if (cycles > LIMIT) begin
            $display("core_pool_allocator regression: fail");
            $finish;
        end
    end

    // one request beat, held until taken
    task send_request(logic fn, logic [cpa_pkg::PID_W-1:0] pid,
                      logic [cpa_pkg::WANT_W-1:0] want);
        @(negedge i_clk);
        start = 1; i_func = fn; i_app_id = pid; i_want_count = want;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_request(fn, pid, want);
    endtask

    task idle_cycles(int n);
        @(negedge i_clk);
        start = 0;
        repeat (n) @(posedge i_clk);
    endtask

    // random gap between requests
    task maybe_idle();
        if (!calm && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 8));
    endtask

    // wait until every expected beat is in and the block is quiet
    task drain();
        @(negedge i_clk);
        start = 0;
        while (sb.grants.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_mask(logic [cpa_pkg::MASK_W-1:0] m);
        @(negedge i_clk);
        i_mask_we = 1; i_mask_wdata = m;
        @(negedge i_clk);
        i_mask_we = 0;
        sb.mask = m;
    endtask

    task random_request();
        logic [cpa_pkg::PID_W-1:0]  pid;
        logic [cpa_pkg::WANT_W-1:0] want;
        int r;
        r = $urandom_range(0, 99);
        pid = (r < 6) ? cpa_pkg::PID_W'($urandom) : pid_pool[$urandom_range(0, 9)];
        want = ($urandom_range(0, 5) == 0) ? cpa_pkg::WANT_W'($urandom)
                                           : cpa_pkg::WANT_W'($urandom_range(0, 16));
        send_request(($urandom_range(0, 4) == 0) ? cpa_pkg::FUNC_REL : cpa_pkg::FUNC_SET,
                     pid, want);
        maybe_idle();
    endtask

    initial begin
        logic [cpa_pkg::MASK_W-1:0] masks[4];
        pid_pool[0] = '0;
        pid_pool[1] = '1;
        for (int i = 2; i < 10; i++) pid_pool[i] = cpa_pkg::PID_W'($urandom);
        masks[0] = 16'h0000; masks[1] = 16'hA5A5; masks[2] = cpa_pkg::MASK_W'($urandom);
        masks[3] = 16'hFFFF;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        while (busy !== 1'b0) @(posedge i_clk);

        // directed: want 0, full grant, oversize want, shrink, release, unknown release
        send_request(cpa_pkg::FUNC_SET, '0, 5'd0);
        send_request(cpa_pkg::FUNC_SET, '1, 5'd16);
        send_request(cpa_pkg::FUNC_SET, '0, 5'd31);
        send_request(cpa_pkg::FUNC_SET, '1, 5'd3);
        send_request(cpa_pkg::FUNC_SET, '0, 5'd31);
        send_request(cpa_pkg::FUNC_REL, 23'h2AAAAA, 5'd0);
        send_request(cpa_pkg::FUNC_REL, '1, 5'd0);
        // fill the table, then one more pid is refused
        for (int i = 2; i < 9; i++)
            send_request(cpa_pkg::FUNC_SET, cpa_pkg::PID_W'(i * 23'h0A5A5), 5'd1);
        send_request(cpa_pkg::FUNC_SET, 23'h555555, 5'd2);
        for (int i = 2; i < 9; i++)
            send_request(cpa_pkg::FUNC_REL, cpa_pkg::PID_W'(i * 23'h0A5A5), 5'd0);
        send_request(cpa_pkg::FUNC_REL, '0, 5'd0);
        drain();

        // mask cleared: growing finds nothing, empty holding stays allocated
        write_mask(16'h0000);
        send_request(cpa_pkg::FUNC_SET, 23'h000123, 5'd4);
        send_request(cpa_pkg::FUNC_REL, 23'h000123, 5'd0);
        drain();
        write_mask(16'hFFFF);

        // random phases, each under its own mask
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 3) calm = 1;
            for (int n = 0; n < 85; n++) random_request();
            drain();
            write_mask(masks[ph]);
        end
        for (int i = 0; i < 10; i++) send_request(cpa_pkg::FUNC_REL, pid_pool[i], 5'd0);
        drain();

        if (sb.grants.size() != 0) sb.report("expected beats never arrived");
        if (sb.errors == 0) begin
            $display("core_pool_allocator regression: pass");
        end else begin
            $display("core_pool_allocator regression: fail");
        end
        $finish;
    end
endmodule
